// ----- src/flam_pkg.sv -----
// Package for the four-level alarm monitor: constants, types and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package flam_pkg;

  localparam int unsigned LogDepthDef    = 128;
  localparam int unsigned NumChannelsDef = 8;
  localparam logic [15:0] ClearHiMul     = 16'd32113;
  localparam logic [15:0] ClearLoMul     = 16'd33423;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_RAISE = 2'd1,
    EV_CLEAR = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_SCAN,
    ST_EMIT,
    ST_ACK_SCAN,
    ST_ACK_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the input item
    logic mul;        // register limit * clear factor
    logic eval;       // decide the event of the current level
    logic scan_start; // reset the scan index
    logic scan_step;  // one log entry per cycle (clear or ack)
    logic ack_mode;   // scan acknowledges instead of clearing
    logic emit;       // drive one result
    logic next_lvl;   // advance to the next level
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic mode;
    logic is_clear;  // evaluated level clears
    logic scan_done; // scan finished: every entry read and written back
    logic lvl_last;  // current level is LL
  } stat_t;

endpackage

// ----- src/four_level_alarm_monitor_top.sv -----
// Four-level (HH/H/L/LL) alarm monitor with hysteresis and a circular log.
// A check item keeps busy high while it walks the four levels: per level a
// multiply, a compare and an emit state, plus a scan of the log memory (one
// entry per cycle) when the level clears. An acknowledge item scans the whole
// log and then emits one result. One item at a time, the next transfer is
// taken in the first idle cycle; results are strobed by valid_o and cannot
// be stalled. rst_ni clears all control, level masks, log fill and counters.
`timescale 1ns / 1ps
module four_level_alarm_monitor_top #(
  parameter int unsigned LOG_DEPTH    = flam_pkg::LogDepthDef,
  parameter int unsigned NUM_CHANNELS = flam_pkg::NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [2:0]         channel_i,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [31:0] hh_limit_i,
  input  logic signed [31:0] h_limit_i,
  input  logic signed [31:0] l_limit_i,
  input  logic signed [31:0] ll_limit_i,
  input  logic [3:0]         limit_enable_i,
  output logic               valid_o,
  output logic [1:0]         level_o,
  output logic [1:0]         event_res_o,
  output logic [2:0]         alarm_channel_o,
  output logic [15:0]        alarm_id_o,
  output logic signed [31:0] limit_out_o,
  output logic signed [31:0] value_out_o,
  output logic [15:0]        active_count_o,
  output logic [15:0]        unacked_count_o,
  output logic               last_o
);
  import flam_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: walks levels, starts log scans, strobes each result transfer
  flam_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // datapath: item hold, limit compare, log memory and saturating counters
  flam_dp #(
    .LOG_DEPTH   (LOG_DEPTH),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .mode_i         (mode_i),
    .channel_i      (channel_i),
    .sample_value_i (sample_value_i),
    .hh_limit_i     (hh_limit_i),
    .h_limit_i      (h_limit_i),
    .l_limit_i      (l_limit_i),
    .ll_limit_i     (ll_limit_i),
    .limit_enable_i (limit_enable_i),
    .valid_o        (valid_o),
    .level_o        (level_o),
    .event_res_o    (event_res_o),
    .alarm_channel_o(alarm_channel_o),
    .alarm_id_o     (alarm_id_o),
    .limit_out_o    (limit_out_o),
    .value_out_o    (value_out_o),
    .active_count_o (active_count_o),
    .unacked_count_o(unacked_count_o),
    .last_o         (last_o)
  );

endmodule

// ----- src/flam_ctrl.sv -----
// Controller state machine of the alarm monitor.
// Depends on flam_pkg.
`timescale 1ns / 1ps
module flam_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  flam_pkg::stat_t stat_i,
  output flam_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import flam_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = stat_i.mode ? ST_ACK_SCAN : ST_EVAL;
      end
      ST_EVAL: begin
        state_d = stat_i.is_clear ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        state_d = stat_i.lvl_last ? ST_IDLE : ST_MUL;
      end
      ST_ACK_SCAN: begin
        if (stat_i.scan_done) state_d = ST_ACK_EMIT;
      end
      ST_ACK_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        ctrl_o.load = start_i;
      end
      ST_MUL: begin
        ctrl_o.mul        = 1'b1;
        ctrl_o.scan_start = 1'b1;
      end
      ST_EVAL: ctrl_o.eval = 1'b1;
      ST_SCAN: ctrl_o.scan_step = 1'b1;
      ST_EMIT: begin
        ctrl_o.emit     = 1'b1;
        ctrl_o.next_lvl = 1'b1;
      end
      ST_ACK_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        ctrl_o.ack_mode  = 1'b1;
      end
      ST_ACK_EMIT: begin
        ctrl_o.emit     = 1'b1;
        ctrl_o.ack_mode = 1'b1;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

// ----- src/flam_dp.sv -----
// Datapath of the alarm monitor: item registers, hysteresis compare,
// alarm log and counters. Depends on flam_pkg.
`timescale 1ns / 1ps
module flam_dp #(
  parameter int unsigned LOG_DEPTH    = flam_pkg::LogDepthDef,
  parameter int unsigned NUM_CHANNELS = flam_pkg::NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flam_pkg::ctrl_t    ctrl_i,
  output flam_pkg::stat_t    stat_o,
  input  logic               mode_i,
  input  logic [2:0]         channel_i,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [31:0] hh_limit_i,
  input  logic signed [31:0] h_limit_i,
  input  logic signed [31:0] l_limit_i,
  input  logic signed [31:0] ll_limit_i,
  input  logic [3:0]         limit_enable_i,
  output logic               valid_o,
  output logic [1:0]         level_o,
  output logic [1:0]         event_res_o,
  output logic [2:0]         alarm_channel_o,
  output logic [15:0]        alarm_id_o,
  output logic signed [31:0] limit_out_o,
  output logic signed [31:0] value_out_o,
  output logic [15:0]        active_count_o,
  output logic [15:0]        unacked_count_o,
  output logic               last_o
);
  import flam_pkg::*;

  localparam int unsigned IdxW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // log entry: valid, active, acked, level[1:0], channel[2:0]
  typedef struct packed {
    logic       valid;
    logic       active;
    logic       acked;
    logic [1:0] lvl;
    logic [2:0] ch;
  } entry_t;

  logic               mode_q;
  logic [2:0]         ch_q;
  logic signed [31:0] val_q;
  logic signed [31:0] lim_q [4];
  logic [3:0]         en_q;
  logic [1:0]         lvl_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mode_q   <= mode_i;
      ch_q     <= channel_i;
      val_q    <= sample_value_i;
      lim_q[0] <= hh_limit_i;
      lim_q[1] <= h_limit_i;
      lim_q[2] <= l_limit_i;
      lim_q[3] <= ll_limit_i;
      en_q     <= limit_enable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else if (ctrl_i.load) begin
      lvl_q <= '0;
    end else if (ctrl_i.next_lvl) begin
      lvl_q <= lvl_q + 2'd1;
    end
  end

  logic signed [31:0] lim_cur;
  logic               high;
  logic signed [48:0] prod_q;
  logic signed [33:0] clr_lim;
  assign lim_cur = lim_q[lvl_q];
  assign high    = ~lvl_q[1];
  // arithmetic shift floors the division by 32768
  assign clr_lim = 34'(prod_q >>> 15);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= 49'(lim_cur) * 49'($signed({1'b0, high ? ClearHiMul : ClearLoMul}));
    end
  end

  // per-channel level masks in flops (reset clears)
  logic [3:0] lvl_act_q [NUM_CHANNELS];
  logic [ChW-1:0] ch_idx;
  logic       ch_ok;
  logic       on;
  logic       raise;
  logic       clr;
  logic       en_cur;
  assign ch_idx = ChW'(ch_q);
  assign ch_ok  = 32'(ch_q) < NUM_CHANNELS;
  assign en_cur = en_q[lvl_q] & ch_ok;
  assign on     = ch_ok ? lvl_act_q[ch_idx][lvl_q] : 1'b0;
  assign raise  = high ? (val_q > lim_cur) : (val_q < lim_cur);
  assign clr    = high ? (34'(val_q) <= clr_lim) : (34'(val_q) >= clr_lim);

  event_e ev_q;
  logic [15:0] id_q;
  logic [15:0] next_id_q;
  logic [15:0] act_q;
  logic [15:0] unack_q;
  logic [IdxW-1:0] head_q;
  logic [IdxW:0]   fill_q;
  logic [IdxW:0]   scan_q;

  // entries below the fill count have been written
  entry_t log_mem [LOG_DEPTH];
  entry_t rd_q;
  logic   rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic   do_raise;
  assign do_raise = ctrl_i.eval & en_cur & ~on & raise;

  // scan: address issued each cycle, registered read, write-back next cycle
  logic [IdxW-1:0] scan_idx;
  logic            scan_issue;
  logic            hit;
  assign scan_idx   = scan_q[IdxW-1:0];
  assign scan_issue = ctrl_i.scan_step & (32'(scan_q) < LOG_DEPTH);
  assign hit = rd_vld_q & ({1'b0, rd_idx_q} < fill_q) &
               (ctrl_i.ack_mode ? ~rd_q.acked
                                : (rd_q.active & rd_q.ch == ch_q & rd_q.lvl == lvl_q));
  assign stat_o.scan_done = ctrl_i.scan_step & (32'(scan_q) >= LOG_DEPTH) & ~rd_vld_q;
  assign stat_o.mode      = mode_q;
  assign stat_o.is_clear  = en_cur & on & clr;
  assign stat_o.lvl_last  = (lvl_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (scan_issue) begin
      rd_q     <= log_mem[scan_idx];
      rd_idx_q <= scan_idx;
    end
    if (do_raise) begin
      log_mem[head_q] <= '{valid: 1'b1, active: 1'b1, acked: 1'b0,
                           lvl: lvl_q, ch: ch_q};
    end else if (hit) begin
      if (ctrl_i.ack_mode) log_mem[rd_idx_q].acked <= 1'b1;
      else                 log_mem[rd_idx_q].active <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      fill_q    <= '0;
      head_q    <= '0;
      next_id_q <= '0;
      act_q     <= '0;
      unack_q   <= '0;
      ev_q      <= EV_NONE;
      id_q      <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) lvl_act_q[i] <= '0;
    end else begin
      rd_vld_q <= scan_issue;
      if (ctrl_i.scan_start) begin
        scan_q <= '0;
      end else if (scan_issue) begin
        scan_q <= scan_q + 1'b1;
      end
      if (hit) begin
        if (ctrl_i.ack_mode) begin
          if (unack_q != '0) unack_q <= unack_q - 16'd1;
        end else if (act_q != '0) begin
          act_q <= act_q - 16'd1;
        end
      end
      if (ctrl_i.eval) begin
        if (en_cur & ~on & raise) begin
          ev_q <= EV_RAISE;
          id_q <= next_id_q;
          next_id_q <= next_id_q + 16'd1;
          lvl_act_q[ch_idx][lvl_q] <= 1'b1;
          if (32'(fill_q) < LOG_DEPTH) fill_q <= fill_q + 1'b1;
          head_q <= (32'(head_q) == LOG_DEPTH - 1) ? '0 : head_q + 1'b1;
          if (act_q != 16'hFFFF)   act_q   <= act_q + 16'd1;
          if (unack_q != 16'hFFFF) unack_q <= unack_q + 16'd1;
        end else if (en_cur & on & clr) begin
          ev_q <= EV_CLEAR;
          id_q <= '0;
          lvl_act_q[ch_idx][lvl_q] <= 1'b0;
        end else begin
          ev_q <= EV_NONE;
          id_q <= '0;
        end
      end
    end
  end

  // results go straight out of the item registers during the emit cycle
  always_comb begin
    valid_o         = ctrl_i.emit;
    active_count_o  = act_q;
    unacked_count_o = unack_q;
    alarm_channel_o = ch_q;
    if (ctrl_i.ack_mode) begin
      level_o     = '0;
      event_res_o = EV_NONE;
      alarm_id_o  = '0;
      limit_out_o = '0;
      value_out_o = '0;
      last_o      = 1'b1;
    end else begin
      level_o     = lvl_q;
      event_res_o = ev_q;
      alarm_id_o  = id_q;
      limit_out_o = lim_cur;
      value_out_o = val_q;
      last_o      = (lvl_q == 2'd3);
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for four_level_alarm_monitor_top: drives sample and
// acknowledge transfers and checks every strobed result against a model
// of the alarm log kept here. Depends on flam_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import flam_pkg::*;

  localparam int LogDepth   = 128;
  localparam int CycleLimit = 2000000;
  localparam bit ModeCheck  = 1'b0;
  localparam bit ModeAck    = 1'b1;
  localparam logic [1:0] LvlHH = 2'd0;

  typedef struct {
    logic [1:0]         level;
    event_e             ev;
    logic [2:0]         chan;
    logic [15:0]        id;
    logic signed [31:0] lim;
    logic signed [31:0] val;
    logic [15:0]        active;
    logic [15:0]        unacked;
    logic               last;
  } alarm_result_t;

  logic clk_i, rst_ni, start, busy;
  logic mode_i;
  logic [2:0] channel_i;
  logic signed [31:0] sample_value_i, hh_limit_i, h_limit_i, l_limit_i, ll_limit_i;
  logic [3:0] limit_enable_i;
  logic valid_o, last_o;
  logic [1:0] level_o, event_res_o;
  logic [2:0] alarm_channel_o;
  logic [15:0] alarm_id_o, active_count_o, unacked_count_o;
  logic signed [31:0] limit_out_o, value_out_o;

  four_level_alarm_monitor_top dut (.*);

  // Alarm state mirrored from the block's behavior
  logic [3:0]  level_on [8];
  bit          ent_valid [LogDepth];
  bit          ent_active [LogDepth];
  bit          ent_acked [LogDepth];
  logic [1:0]  ent_level [LogDepth];
  logic [2:0]  ent_chan [LogDepth];
  int          log_wr;
  logic [15:0] next_id, active_total, unacked_total;

  alarm_result_t pending_results[$];
  int  mismatches;
  int  cycles;
  bit  gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Clear threshold: floor(limit * factor / 32768)
  function automatic longint clear_level(logic signed [31:0] lim, bit high);
    longint prod;
    prod = longint'(lim) * (high ? longint'(ClearHiMul) : longint'(ClearLoMul));
    return prod >>> 15;
  endfunction

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] sat_down(logic [15:0] v);
    return (v == 16'd0) ? v : v - 16'd1;
  endfunction

  // Work out the results of one accepted transfer and queue them
  task automatic predict_alarms(bit m, logic [2:0] ch, logic signed [31:0] v,
                                logic signed [31:0] lims [4], logic [3:0] en);
    alarm_result_t r;
    bit on, high, raise, clr;
    longint thr;
    if (m == ModeAck) begin
      for (int i = 0; i < LogDepth; i++)
        if (ent_valid[i] && !ent_acked[i]) begin
          ent_acked[i] = 1'b1;
          unacked_total = sat_down(unacked_total);
        end
      r = '{LvlHH, EV_NONE, ch, 16'd0, 32'sd0, 32'sd0, active_total, unacked_total, 1'b1};
      pending_results.push_back(r);
      return;
    end
    for (int lv = 0; lv < 4; lv++) begin
      r = '{lv[1:0], EV_NONE, ch, 16'd0, lims[lv], v, 16'd0, 16'd0, lv == 3};
      if (en[lv]) begin
        on    = level_on[ch][lv];
        high  = lv < 2;
        thr   = clear_level(lims[lv], high);
        raise = high ? (v > lims[lv]) : (v < lims[lv]);
        clr   = high ? (longint'(v) <= thr) : (longint'(v) >= thr);
        if (!on && raise) begin
          level_on[ch][lv]  = 1'b1;
          r.id              = next_id;
          r.ev              = EV_RAISE;
          next_id           = next_id + 16'd1;
          ent_valid[log_wr] = 1'b1;
          ent_active[log_wr] = 1'b1;
          ent_acked[log_wr] = 1'b0;
          ent_level[log_wr] = lv[1:0];
          ent_chan[log_wr]  = ch;
          log_wr            = (log_wr + 1) % LogDepth;
          active_total      = sat_up(active_total);
          unacked_total     = sat_up(unacked_total);
        end else if (on && clr) begin
          level_on[ch][lv] = 1'b0;
          r.ev             = EV_CLEAR;
          for (int i = 0; i < LogDepth; i++)
            if (ent_valid[i] && ent_active[i] && ent_chan[i] == ch && ent_level[i] == lv) begin
              ent_active[i] = 1'b0;
              active_total  = sat_down(active_total);
            end
        end
      end
      r.active  = active_total;
      r.unacked = unacked_total;
      pending_results.push_back(r);
    end
  endtask

  // Send one transfer; start stays high afterwards so back-to-back items
  // never drop it within a step
  task automatic send_item(bit m, logic [2:0] ch, logic signed [31:0] v,
                           logic signed [31:0] hh, logic signed [31:0] h,
                           logic signed [31:0] l, logic signed [31:0] ll,
                           logic [3:0] en);
    logic signed [31:0] lims [4];
    lims = '{hh, h, l, ll};
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start          <= 1'b1;
    mode_i         <= m;
    channel_i      <= ch;
    sample_value_i <= v;
    hh_limit_i     <= hh;
    h_limit_i      <= h;
    l_limit_i      <= l;
    ll_limit_i     <= ll;
    limit_enable_i <= en;
    // Busy read right after the edge still holds its pre-edge value
    do @(posedge clk_i); while (busy);
    predict_alarms(m, ch, v, lims, en);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Compare every strobed result with the oldest expectation
  always @(posedge clk_i) begin
    alarm_result_t e;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: level %0d event %0d", level_o, event_res_o);
      end else begin
        e = pending_results.pop_front();
        if (level_o !== e.level || event_res_o !== e.ev || alarm_channel_o !== e.chan ||
            alarm_id_o !== e.id || limit_out_o !== e.lim || value_out_o !== e.val ||
            active_count_o !== e.active || unacked_count_o !== e.unacked ||
            last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp lvl%0d ev%0d ch%0d id%0d lim%0d val%0d act%0d un%0d last%0d",
                     e.level, e.ev, e.chan, e.id, e.lim, e.val, e.active, e.unacked, e.last,
                     "\n         got lvl%0d ev%0d ch%0d id%0d lim%0d val%0d act%0d un%0d last%0d",
                     level_o, event_res_o, alarm_channel_o, alarm_id_o, limit_out_o,
                     value_out_o, active_count_o, unacked_count_o, last_o);
        end
      end
    end
  end

  // Boundaries, every level raising and clearing, negative limits, extremes
  task automatic test_directed();
    logic signed [31:0] lim, thr;
    gaps_on = 1'b1;
    // acknowledge with an empty log: unacked clamps at zero
    send_item(ModeAck, 3'd5, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'h0);
    // disabled levels test nothing even at the extremes
    send_item(ModeCheck, 3'd0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 4'h0);
    // value equal to a high limit does not raise, one above does
    lim = 32'sd100 <<< 16;
    send_item(ModeCheck, 3'd1, lim, lim, lim, -lim, -lim, 4'h3);
    send_item(ModeCheck, 3'd1, lim + 1, lim, lim, -lim, -lim, 4'h3);
    thr = 32'(clear_level(lim, 1'b1));
    send_item(ModeCheck, 3'd1, thr + 1, lim, lim, -lim, -lim, 4'h3);
    send_item(ModeCheck, 3'd1, thr, lim, lim, -lim, -lim, 4'h3);
    // low levels with negative limits: floor rounds away from zero
    lim = -(32'sd7 <<< 16) - 32'sd3;
    thr = 32'(clear_level(lim, 1'b0));
    send_item(ModeCheck, 3'd2, lim, 32'sd0, 32'sd0, lim, lim, 4'hC);
    send_item(ModeCheck, 3'd2, lim - 1, 32'sd0, 32'sd0, lim, lim, 4'hC);
    send_item(ModeAck, 3'd2, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'hF);
    send_item(ModeCheck, 3'd2, thr - 1, 32'sd0, 32'sd0, lim, lim, 4'hC);
    send_item(ModeCheck, 3'd2, thr, 32'sd0, 32'sd0, lim, lim, 4'hC);
    // full-scale values and limits on all levels
    send_item(ModeCheck, 3'd7, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 4'hF);
    send_item(ModeCheck, 3'd7, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 4'hF);
    send_item(ModeCheck, 3'd7, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 4'hF);
    send_item(ModeAck, 3'd7, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'h0);
    wait_drained();
  endtask

  // Overrun the log so an active entry is overwritten and never cleared
  task automatic test_log_overrun();
    logic signed [31:0] hi, lo;
    gaps_on = 1'b0;
    hi = 32'sd50 <<< 16;
    lo = -hi;
    send_item(ModeCheck, 3'd6, hi + 1, hi, hi, lo, lo, 4'h2);
    for (int i = 0; i < 70; i++)
      send_item(ModeCheck, 3'd0, (i % 2) ? lo - 32'sd65536 : hi + 32'sd65536,
                hi, hi, lo, lo, 4'hF);
    send_item(ModeCheck, 3'd6, 32'sd0, hi, hi, lo, lo, 4'h2);
    send_item(ModeAck, 3'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'h0);
    wait_drained();
  endtask

  // Mostly values near limits or clear thresholds on ordered limit sets,
  // with some acknowledges and a share of fully random items
  task automatic test_random(int count);
    logic signed [31:0] lims [8][4];
    logic signed [31:0] v, base;
    logic [2:0] ch;
    longint near;
    int lv;
    gaps_on = 1'b1;
    for (int c = 0; c < 8; c++) begin
      base = -32'($urandom_range(0, 10000)) <<< 16;
      lims[c][3] = base + 32'($urandom_range(0, 65535));
      lims[c][2] = lims[c][3] + (32'($urandom_range(1, 3000)) <<< 16);
      lims[c][1] = lims[c][2] + (32'($urandom_range(1, 3000)) <<< 16);
      lims[c][0] = lims[c][1] + (32'($urandom_range(1, 3000)) <<< 16);
    end
    for (int n = 0; n < count; n++) begin
      ch = 3'($urandom_range(0, 7));
      if (n == count / 2) wait_drained();
      if ($urandom_range(0, 99) < 6) begin
        send_item(ModeAck, ch, $urandom, $urandom, $urandom, $urandom, $urandom,
                  4'($urandom));
      end else if ($urandom_range(0, 99) < 15) begin
        send_item(ModeCheck, ch, $urandom, $urandom, $urandom, $urandom, $urandom,
                  4'($urandom));
      end else begin
        lv = $urandom_range(0, 3);
        near = $urandom_range(0, 1) ? longint'(lims[ch][lv])
                                    : clear_level(lims[ch][lv], lv < 2);
        near = near + $urandom_range(0, 6) - 3;
        v = 32'(near);
        send_item(ModeCheck, ch, v, lims[ch][0], lims[ch][1], lims[ch][2], lims[ch][3],
                  ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF);
      end
    end
    wait_drained();
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    gaps_on = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = 1'b0;
    channel_i = '0;
    sample_value_i = '0;
    hh_limit_i = '0;
    h_limit_i = '0;
    l_limit_i = '0;
    ll_limit_i = '0;
    limit_enable_i = '0;
    for (int c = 0; c < 8; c++) level_on[c] = 4'h0;
    for (int i = 0; i < LogDepth; i++) begin
      ent_valid[i] = 1'b0;
      ent_active[i] = 1'b0;
      ent_acked[i] = 1'b0;
    end
    log_wr = 0;
    next_id = '0;
    active_total = '0;
    unacked_total = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_log_overrun();
    test_random(45);

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
